/* rtl/acr_pkg.sv */
// Shared types and widths for the box pair collision resolver.
// Used by acr_front, acr_div_cell and aabb_pair_collision_resolve.
`timescale 1ns / 1ps
package acr_pkg;

  // quotient bits per lane (one divider cell per bit)
  localparam int QW = 14;
  // doubled divisor width, remainder width
  localparam int DW = 18;
  // dividend width
  localparam int NW = 31;

  // per-item control carried alongside the divider lanes
  typedef struct packed {
    logic       resolved;
    logic       on_x;
    logic       pos;
    logic [3:0] locks;
  } acr_side_t;

  // one divider lane: partial remainder and combined dividend/quotient shifter
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] lq;
  } acr_lane_t;

endpackage

/* rtl/acr_front.sv */
// Front end: overlap test, axis choice, share selection and dividend forming.
// Two register stages; depends on acr_pkg.
`timescale 1ns / 1ps
module acr_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_fire,
  input  logic signed [15:0]        a_x,
  input  logic signed [15:0]        a_y,
  input  logic [13:0]               a_w,
  input  logic [13:0]               a_h,
  input  logic signed [15:0]        b_x,
  input  logic signed [15:0]        b_y,
  input  logic [13:0]               b_w,
  input  logic [13:0]               b_h,
  input  logic [15:0]               mass_a,
  input  logic [15:0]               mass_b,
  input  logic [3:0]                axis_locks,
  input  logic                      pair_eligible,
  output logic                      vld,
  output acr_pkg::acr_side_t        side,
  output acr_pkg::acr_lane_t        lane_a,
  output acr_pkg::acr_lane_t        lane_b,
  output logic [acr_pkg::DW-1:0]    dvs
);

  // stage 1 geometry
  logic signed [18:0] dx, dy;
  logic [18:0]        adx, ady;
  logic signed [19:0] ox, oy;
  logic               ok, on_x_c, pos_c;
  logic [14:0]        depth_c;

  always_comb begin
    dx = (19'(a_x) * 19'sd2 + 19'(signed'({1'b0, a_w})))
       - (19'(b_x) * 19'sd2 + 19'(signed'({1'b0, b_w})));
    dy = (19'(a_y) * 19'sd2 + 19'(signed'({1'b0, a_h})))
       - (19'(b_y) * 19'sd2 + 19'(signed'({1'b0, b_h})));
    adx = dx[18] ? 19'(-dx) : 19'(dx);
    ady = dy[18] ? 19'(-dy) : 19'(dy);
    ox = signed'(20'({5'd0, a_w} + {5'd0, b_w})) - signed'({1'b0, adx});
    oy = signed'(20'({5'd0, a_h} + {5'd0, b_h})) - signed'({1'b0, ady});
    ok = pair_eligible && (ox > 20'sd0) && (oy > 20'sd0);
    on_x_c = ox < oy;
    depth_c = on_x_c ? ox[14:0] : oy[14:0];
    pos_c = on_x_c ? (dx > 19'sd0) : (dy > 19'sd0);
  end

  logic               v1;
  acr_pkg::acr_side_t s1;
  logic [14:0]        depth1;
  logic [15:0]        ma1, mb1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.resolved <= ok;
      s1.on_x     <= on_x_c;
      s1.pos      <= pos_c;
      s1.locks    <= axis_locks;
      depth1      <= ok ? depth_c : 15'd0;
      ma1         <= mass_a;
      mb1         <= mass_b;
    end
  end

  // stage 2: pick share numerators and denominator, form dividends
  logic [15:0]            num_a, num_b;
  logic [16:0]            den;
  logic [acr_pkg::NW-1:0] n_a, n_b;

  always_comb begin
    num_a = 16'd0;
    num_b = 16'd0;
    den   = 17'd1;
    priority if (ma1 != 16'd0 && mb1 == 16'd0) begin
      num_a = 16'd1;
    end else if (mb1 != 16'd0 && ma1 == 16'd0) begin
      num_b = 16'd1;
    end else if (ma1 != 16'd0 && mb1 != 16'd0) begin
      num_a = mb1;
      num_b = ma1;
      den   = {1'b0, ma1} + {1'b0, mb1};
    end else begin
      // both static: zero shares
      den   = 17'd1;
    end
    n_a = acr_pkg::NW'({16'd0, depth1} * {15'd0, num_a}) + acr_pkg::NW'(den);
    n_b = acr_pkg::NW'({16'd0, depth1} * {15'd0, num_b}) + acr_pkg::NW'(den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side       <= s1;
      lane_a.rem <= acr_pkg::DW'(n_a[acr_pkg::NW-1:acr_pkg::QW]);
      lane_a.lq  <= n_a[acr_pkg::QW-1:0];
      lane_b.rem <= acr_pkg::DW'(n_b[acr_pkg::NW-1:acr_pkg::QW]);
      lane_b.lq  <= n_b[acr_pkg::QW-1:0];
      dvs        <= {den, 1'b0};
    end
  end

endmodule

/* rtl/acr_div_cell.sv */
// One restoring division cell: one quotient bit for each of two lanes.
// Depends on acr_pkg.
`timescale 1ns / 1ps
module acr_div_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      vld_i,
  input  acr_pkg::acr_side_t        side_i,
  input  acr_pkg::acr_lane_t        lane_a_i,
  input  acr_pkg::acr_lane_t        lane_b_i,
  input  logic [acr_pkg::DW-1:0]    dvs_i,
  output logic                      vld_o,
  output acr_pkg::acr_side_t        side_o,
  output acr_pkg::acr_lane_t        lane_a_o,
  output acr_pkg::acr_lane_t        lane_b_o,
  output logic [acr_pkg::DW-1:0]    dvs_o
);

  logic [acr_pkg::DW:0] t_a, t_b;
  logic                 q_a, q_b;
  acr_pkg::acr_lane_t   nx_a, nx_b;

  // shift in next dividend bit, trial subtract
  always_comb begin
    t_a = {lane_a_i.rem, lane_a_i.lq[acr_pkg::QW-1]};
    t_b = {lane_b_i.rem, lane_b_i.lq[acr_pkg::QW-1]};
    q_a = t_a >= {1'b0, dvs_i};
    q_b = t_b >= {1'b0, dvs_i};
    nx_a.rem = q_a ? acr_pkg::DW'(t_a - {1'b0, dvs_i}) : acr_pkg::DW'(t_a);
    nx_b.rem = q_b ? acr_pkg::DW'(t_b - {1'b0, dvs_i}) : acr_pkg::DW'(t_b);
    nx_a.lq  = {lane_a_i.lq[acr_pkg::QW-2:0], q_a};
    nx_b.lq  = {lane_b_i.lq[acr_pkg::QW-2:0], q_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (adv) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_o   <= side_i;
      lane_a_o <= nx_a;
      lane_b_o <= nx_b;
      dvs_o    <= dvs_i;
    end
  end

endmodule

/* rtl/aabb_pair_collision_resolve.sv */
// Top level: front end, chain of divider cells, signed output register.
// Depends on acr_pkg, acr_front, acr_div_cell.
//
//  channel | signals                                   | dir
//  in      | in_valid, in_ready, a_*, b_*, mass_*, ... | item in
//  out     | out_valid, out_ready, move_*, resolved    | item out
//
// Register stages: two front stages, one cell per quotient bit (14), output reg.
// One item per cycle sustained while the output is not stalled; the whole pipe advances together.
// Reset clears the valid bits only.
// A stalled output holds every stage; in_ready drops in that same cycle.
`timescale 1ns / 1ps
module aabb_pair_collision_resolve (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] a_x,
  input  logic signed [15:0] a_y,
  input  logic [13:0]        a_w,
  input  logic [13:0]        a_h,
  input  logic signed [15:0] b_x,
  input  logic signed [15:0] b_y,
  input  logic [13:0]        b_w,
  input  logic [13:0]        b_h,
  input  logic [15:0]        mass_a,
  input  logic [15:0]        mass_b,
  input  logic [3:0]         axis_locks,
  input  logic               pair_eligible,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] move_a_x,
  output logic signed [15:0] move_a_y,
  output logic signed [15:0] move_b_x,
  output logic signed [15:0] move_b_y,
  output logic               resolved
);

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic                   vld  [acr_pkg::QW+1];
  acr_pkg::acr_side_t     side [acr_pkg::QW+1];
  acr_pkg::acr_lane_t     la   [acr_pkg::QW+1];
  acr_pkg::acr_lane_t     lb   [acr_pkg::QW+1];
  logic [acr_pkg::DW-1:0] dvs  [acr_pkg::QW+1];

  acr_front u_front (
    .clk, .rst, .adv,
    .in_fire(in_valid && in_ready),
    .a_x, .a_y, .a_w, .a_h, .b_x, .b_y, .b_w, .b_h,
    .mass_a, .mass_b, .axis_locks, .pair_eligible,
    .vld(vld[0]), .side(side[0]), .lane_a(la[0]), .lane_b(lb[0]), .dvs(dvs[0])
  );

  // divider chain
  for (genvar i = 0; i < acr_pkg::QW; i++) begin : g_cell
    acr_div_cell u_cell (
      .clk, .rst, .adv,
      .vld_i(vld[i]), .side_i(side[i]), .lane_a_i(la[i]), .lane_b_i(lb[i]),
      .dvs_i(dvs[i]),
      .vld_o(vld[i+1]), .side_o(side[i+1]), .lane_a_o(la[i+1]),
      .lane_b_o(lb[i+1]), .dvs_o(dvs[i+1])
    );
  end

  // sign and lock masking
  acr_pkg::acr_side_t sd;
  logic signed [15:0] sa, sb;
  logic               en;

  always_comb begin
    sd = side[acr_pkg::QW];
    sa = 16'(la[acr_pkg::QW].lq);
    sb = 16'(lb[acr_pkg::QW].lq);
    if (!sd.pos) sa = -sa;
    if (sd.pos)  sb = -sb;
    en = sd.resolved;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[acr_pkg::QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      move_a_x <= (en && sd.on_x && sd.locks[0])   ? sa : 16'sd0;
      move_a_y <= (en && !sd.on_x && sd.locks[1])  ? sa : 16'sd0;
      move_b_x <= (en && sd.on_x && sd.locks[2])   ? sb : 16'sd0;
      move_b_y <= (en && !sd.on_x && sd.locks[3])  ? sb : 16'sd0;
      resolved <= en;
    end
  end

  // checks
  a_unres_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !resolved |-> move_a_x == 16'sd0 && move_a_y == 16'sd0
      && move_b_x == 16'sd0 && move_b_y == 16'sd0)
    else $error("unresolved item carries a move");

  a_one_axis: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !((move_a_x != 16'sd0 || move_b_x != 16'sd0)
      && (move_a_y != 16'sd0 || move_b_y != 16'sd0)))
    else $error("moves on both axes");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

/* verif/tb_aabb_pair_collision_resolve.sv */
// Testbench for aabb_pair_collision_resolve: directed and random box pairs,
// checked against a behavioral predictor of the overlap resolution.
// Depends only on the RTL of the block (no package types needed here).
`timescale 1ns / 1ps

typedef struct {
  logic signed [15:0] ax, ay, bx, by;
  logic [13:0]        aw, ah, bw, bh;
  logic [15:0]        ma, mb;
  logic [3:0]         locks;
  logic               elig;
} pair_t;

typedef struct {
  logic signed [15:0] max, may, mbx, mby;
  logic               res;
} moves_t;

class resolve_board;
  moves_t pending[$];
  int     n_bad;
  int     n_ok;
  int     n_resolved;

  // half-up rounding of mag2 * num / (2 * den)
  function automatic longint unsigned share(longint unsigned mag2, longint unsigned num,
                                            longint unsigned den);
    longint unsigned p, d;
    p = mag2 * num;
    d = 2 * den;
    return (2 * p + d) / (2 * d);
  endfunction

  function automatic logic [15:0] signed_mag(longint unsigned mag, bit neg);
    logic [15:0] v;
    v = mag[15:0];
    if (neg) v = 16'(17'h10000 - v);
    return v;
  endfunction

  // predict the corrections for one accepted pair
  function void note_pair(pair_t p);
    moves_t m;
    int dx, dy, ox, oy;
    bit on_x, pos;
    longint unsigned d2, mga, mgb, msum;
    m = '{default: 0};
    mga = 0;
    mgb = 0;
    if (p.elig) begin
      dx = (2 * int'(p.ax) + int'(p.aw)) - (2 * int'(p.bx) + int'(p.bw));
      dy = (2 * int'(p.ay) + int'(p.ah)) - (2 * int'(p.by) + int'(p.bh));
      ox = (int'(p.aw) + int'(p.bw)) - (dx < 0 ? -dx : dx);
      oy = (int'(p.ah) + int'(p.bh)) - (dy < 0 ? -dy : dy);
      if (ox > 0 && oy > 0) begin
        on_x = ox < oy;
        d2 = on_x ? ox : oy;
        pos = on_x ? (dx > 0) : (dy > 0);
        msum = 64'(p.ma) + 64'(p.mb);
        if (p.ma != 0 && p.mb == 0) mga = share(d2, 1, 1);
        else if (p.mb != 0 && p.ma == 0) mgb = share(d2, 1, 1);
        else if (p.ma != 0 && p.mb != 0) begin
          mga = share(d2, p.mb, msum);
          mgb = share(d2, p.ma, msum);
        end
        if (on_x) begin
          if (p.locks[0]) m.max = signed_mag(mga, !pos);
          if (p.locks[2]) m.mbx = signed_mag(mgb, pos);
        end else begin
          if (p.locks[1]) m.may = signed_mag(mga, !pos);
          if (p.locks[3]) m.mby = signed_mag(mgb, pos);
        end
        m.res = 1;
      end
    end
    pending.push_back(m);
  endfunction

  function void check_moves(moves_t got);
    moves_t e;
    if (pending.size() == 0) begin
      n_bad++;
      if (n_bad <= 10) $display("unexpected item out: res=%0d", got.res);
      return;
    end
    e = pending.pop_front();
    if (got.max !== e.max || got.may !== e.may || got.mbx !== e.mbx ||
        got.mby !== e.mby || got.res !== e.res) begin
      n_bad++;
      if (n_bad <= 10)
        $display("mismatch: exp a(%0d,%0d) b(%0d,%0d) r%0d got a(%0d,%0d) b(%0d,%0d) r%0d",
                 e.max, e.may, e.mbx, e.mby, e.res,
                 got.max, got.may, got.mbx, got.mby, got.res);
    end else begin
      n_ok++;
      if (e.res) n_resolved++;
    end
  endfunction
endclass

module tb_aabb_pair_collision_resolve;
  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] a_x, a_y, b_x, b_y;
  logic [13:0]        a_w, a_h, b_w, b_h;
  logic [15:0]        mass_a, mass_b;
  logic [3:0]         axis_locks;
  logic               pair_eligible;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] move_a_x, move_a_y, move_b_x, move_b_y;
  logic               resolved;

  resolve_board board;
  int           n_sent;

  aabb_pair_collision_resolve u_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // present one pair and hold it until accepted
  task automatic send_pair(pair_t p);
    in_valid      <= 1;
    a_x <= p.ax; a_y <= p.ay; a_w <= p.aw; a_h <= p.ah;
    b_x <= p.bx; b_y <= p.by; b_w <= p.bw; b_h <= p.bh;
    mass_a        <= p.ma;
    mass_b        <= p.mb;
    axis_locks    <= p.locks;
    pair_eligible <= p.elig;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_pair(p);
    n_sent++;
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_mass();
    case ($urandom_range(0, 5))
      0, 1:    return 16'h0;
      2:       return 16'hFFFF;
      3:       return 16'(1 << $urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly overlapping pairs with random geometry, sometimes anything goes
  function automatic pair_t rand_pair();
    pair_t p;
    int    span;
    p.elig  = ($urandom_range(0, 9) != 0);
    p.locks = 4'($urandom);
    p.ma    = pick_mass();
    p.mb    = pick_mass();
    if ($urandom_range(0, 4) == 0) begin
      p.ax = 16'($urandom); p.ay = 16'($urandom);
      p.bx = 16'($urandom); p.by = 16'($urandom);
      p.aw = 14'($urandom); p.ah = 14'($urandom);
      p.bw = 14'($urandom); p.bh = 14'($urandom);
    end else begin
      span = ($urandom_range(0, 3) == 0) ? 16383 : 255;
      p.aw = 14'($urandom_range(0, span)); p.ah = 14'($urandom_range(0, span));
      p.bw = 14'($urandom_range(0, span)); p.bh = 14'($urandom_range(0, span));
      p.ax = 16'($urandom_range(0, 65535 - span)) - 16'sd32768;
      p.ay = 16'($urandom_range(0, 65535 - span)) - 16'sd32768;
      p.bx = p.ax + 16'(int'($urandom_range(0, 2 * span)) - span);
      p.by = p.ay + 16'(int'($urandom_range(0, 2 * span)) - span);
      if ($urandom_range(0, 7) == 0) begin
        p.bx = p.ax;
        p.bw = p.aw;
      end
    end
    return p;
  endfunction

  function automatic pair_t mk(int ax, int ay, int aw, int ah, int bx, int by, int bw,
                               int bh, int ma, int mb, int locks, int elig);
    pair_t p;
    p.ax = 16'(ax); p.ay = 16'(ay); p.aw = 14'(aw); p.ah = 14'(ah);
    p.bx = 16'(bx); p.by = 16'(by); p.bw = 14'(bw); p.bh = 14'(bh);
    p.ma = 16'(ma); p.mb = 16'(mb); p.locks = 4'(locks); p.elig = 1'(elig);
    return p;
  endfunction

  // receiver: drives a random out_ready, mostly high, with occasional stalls
  initial begin
    out_ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (($urandom_range(0, 255) & 8'h40) != 0) out_ready <= 1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    moves_t got;
    if (!rst && out_valid && out_ready) begin
      got.max = move_a_x; got.may = move_a_y;
      got.mbx = move_b_x; got.mby = move_b_y;
      got.res = resolved;
      board.check_moves(got);
    end
  end

  initial begin
    pair_t p;
    int    burst;
    int    wait_cnt;
    board = new();
    n_sent = 0;
    rst = 1;
    in_valid = 0;
    {a_x, a_y, b_x, b_y, mass_a, mass_b} = '0;
    {a_w, a_h, b_w, b_h, axis_locks, pair_eligible} = '0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: not eligible, touching, zero size, ties, static pairs, extremes
    send_pair(mk(0, 0, 32, 32, 16, 16, 32, 32, 256, 256, 15, 0));
    send_pair(mk(0, 0, 32, 32, 32, 0, 32, 32, 256, 256, 15, 1));
    send_pair(mk(0, 0, 0, 0, 0, 0, 32, 32, 256, 256, 15, 1));
    send_pair(mk(0, 0, 32, 32, 16, 16, 32, 32, 256, 256, 15, 1));
    send_pair(mk(0, 0, 32, 32, 0, 0, 32, 32, 256, 256, 15, 1));
    send_pair(mk(0, 0, 32, 32, 10, 2, 32, 32, 0, 0, 15, 1));
    send_pair(mk(0, 0, 32, 32, 10, 2, 32, 32, 100, 0, 15, 1));
    send_pair(mk(0, 0, 32, 32, 2, 10, 32, 32, 0, 100, 15, 1));
    send_pair(mk(0, 0, 32, 32, 2, 10, 32, 32, 1, 65535, 15, 1));
    send_pair(mk(0, 0, 33, 31, -3, -5, 7, 9, 65535, 65535, 15, 1));
    send_pair(mk(0, 0, 32, 32, 10, 2, 32, 32, 100, 300, 10, 1));
    send_pair(mk(0, 0, 32, 32, 2, 10, 32, 32, 100, 300, 5, 1));
    send_pair(mk(-32768, -32768, 16383, 16383, -32768, -32768, 16383, 16383,
                 65535, 0, 15, 1));
    send_pair(mk(32767, 32767, 16383, 16383, 32767, 32767, 16383, 16383,
                 0, 65535, 15, 1));
    send_pair(mk(-32768, 32767, 16383, 16383, 32767, -32768, 16383, 16383,
                 3, 5, 15, 1));
    send_pair(mk(-1, -1, 1, 1, -1, -1, 1, 1, 3, 7, 15, 1));
    send_pair(mk(100, 100, 50, 50, 120, 130, 10, 10, 256, 512, 15, 1));

    // hold off until the pipe drains completely
    idle_cycles(1);
    wait_cnt = 0;
    while (board.pending.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end

    // random bursts with gaps
    while (n_sent < 1430) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        p = rand_pair();
        send_pair(p);
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
    end
    in_valid <= 0;

    wait_cnt = 0;
    while (board.pending.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (40) @(posedge clk);

    $display("Sent %0d box pairs, %0d matched, %0d of them with an overlap resolved.",
             n_sent, board.n_ok, board.n_resolved);
    if (board.n_bad == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", board.n_bad, board.pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
